// ----- hdl/brsc_pkg.sv -----
// Shared types and constants of the banker's request safety check block.
package brsc_pkg;

  localparam int unsigned MaxProcesses = 16;
  localparam int unsigned MaxResources = 8;
  localparam int unsigned AmountBits   = 16;

  localparam int unsigned PidxW = $clog2(MaxProcesses);
  localparam int unsigned RidxW = $clog2(MaxResources);
  localparam int unsigned AddrW = PidxW + RidxW;
  localparam int unsigned Depth = MaxProcesses * MaxResources;

  typedef logic [AmountBits-1:0] amount_t;
  typedef logic [PidxW-1:0]      pidx_t;
  typedef logic [RidxW-1:0]      ridx_t;
  typedef logic [AddrW-1:0]      addr_t;

  typedef enum logic [1:0] {
    KIND_CLAIM     = 2'd0,
    KIND_ALLOC     = 2'd1,
    KIND_AVAILABLE = 2'd2,
    KIND_REQUEST   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_GRANTED   = 3'd1,
    ST_EXC_AVAIL = 3'd2,
    ST_EXC_CLAIM = 3'd3,
    ST_UNSAFE    = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  localparam logic CfgProcessCount  = 1'b0;
  localparam logic CfgResourceCount = 1'b1;

  // Adds two amounts and clips at the largest amount.
  function automatic amount_t sat_add(amount_t a, amount_t b);
    logic [AmountBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[AmountBits] ? {AmountBits{1'b1}} : s[AmountBits-1:0];
  endfunction

endpackage

// ----- hdl/bankers_request_safety_check_core.sv -----
// Top level of the banker's request safety check block.
//
// Users should know first: an item is taken when start_i is high and busy_o is low, and every
// result appears on the result ports for exactly one cycle with result_valid_o high; the
// receiver cannot stall it. Table loads, non-final request elements and bad indexes answer in
// the cycle after acceptance, and the block is ready again at once. A final request element
// starts an evaluation that walks the claim and allocation memories one resource element per
// step, each step a memory read and then the shared compare/add unit. It runs the check and,
// if that passes, the grant, the safety search over P processes and R resources, and the
// rollback if no safe order is found. A granted request then emits P results on consecutive
// cycles and runs a release pass; busy_o stays high until that pass ends. Configuration writes
// take effect at once and are expected only while the block is idle.
module bankers_request_safety_check_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            kind_i,
  input  brsc_pkg::pidx_t       process_index_i,
  input  brsc_pkg::ridx_t       resource_index_i,
  input  brsc_pkg::amount_t     amount_i,
  input  logic                  last_element_i,
  output logic                  result_valid_o,
  output logic [2:0]            status_o,
  output brsc_pkg::pidx_t       sequence_process_o,
  output logic                  last_result_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [4:0]            cfg_data_i
);
  import brsc_pkg::*;

  // One-hot sequencer. Each RD state reads the memories at {process, resource};
  // the following EX state uses the registered read data in the shared unit.
  typedef enum logic [16:0] {
    S_IDLE      = 17'b00000000000000001,
    S_CHK_RD    = 17'b00000000000000010,
    S_CHK_EX    = 17'b00000000000000100,
    S_GNT_RD    = 17'b00000000000001000,
    S_GNT_EX    = 17'b00000000000010000,
    S_SAFE_INIT = 17'b00000000000100000,
    S_SAFE_RD   = 17'b00000000001000000,
    S_SAFE_EX   = 17'b00000000010000000,
    S_ADD_RD    = 17'b00000000100000000,
    S_ADD_EX    = 17'b00000001000000000,
    S_ROLL_RD   = 17'b00000010000000000,
    S_ROLL_EX   = 17'b00000100000000000,
    S_EMIT      = 17'b00001000000000000,
    S_REL_RD    = 17'b00010000000000000,
    S_REL_EX    = 17'b00100000000000000,
    S_FREE_RD   = 17'b01000000000000000,
    S_FREE_EX   = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers and the effective counts after clamping.
  logic [4:0] proc_cnt_q;
  logic [3:0] res_cnt_q;
  logic [4:0] np;
  logic [3:0] nr;
  pidx_t      np_m1;
  ridx_t      nr_m1;

  // Claim and allocation memories, each with one valid bit per entry so that
  // entries never loaded read as zero.
  amount_t     clm_mem [Depth];
  amount_t     alc_mem [Depth];
  logic [Depth-1:0] clm_vld_q, alc_vld_q;
  amount_t     clm_rd_q, alc_rd_q;
  logic        clm_rdv_q, alc_rdv_q;
  amount_t     clm_val, alc_val;
  addr_t       rd_addr;
  logic        clm_we, alc_we;
  addr_t       clm_wa, alc_wa;
  amount_t     clm_wd, alc_wd;

  // Small vectors held in flops.
  amount_t avail_q [MaxResources];
  amount_t avail_d [MaxResources];
  amount_t req_q   [MaxResources];
  amount_t req_d   [MaxResources];
  amount_t work_q  [MaxResources];
  amount_t work_d  [MaxResources];
  logic [MaxProcesses-1:0] fin_q, fin_d;
  pidx_t   seq_q [MaxProcesses];
  pidx_t   seq_d [MaxProcesses];

  // Sequencer counters and flags.
  ridx_t j_q, j_d;
  pidx_t i_q, i_d;
  pidx_t pos_q, pos_d;
  pidx_t pr_q, pr_d;
  logic  fa_q, fa_d;
  logic  fc_q, fc_d;

  // Registered result.
  logic    rv_q, rv_d;
  logic [2:0] rs_q, rs_d;
  pidx_t   rp_q, rp_d;
  logic    rl_q, rl_d;

  logic last_j, last_i, last_pos;
  logic in_acc, bad_idx;
  pidx_t p_sel;

  assign np = (proc_cnt_q == 5'd0) ? 5'd1 :
              (proc_cnt_q > 5'(MaxProcesses)) ? 5'(MaxProcesses) : proc_cnt_q;
  assign nr = (res_cnt_q == 4'd0) ? 4'd1 :
              (res_cnt_q > 4'(MaxResources)) ? 4'(MaxResources) : res_cnt_q;
  assign np_m1 = PidxW'(np - 5'd1);
  assign nr_m1 = RidxW'(nr - 4'd1);

  assign last_j   = (j_q == nr_m1);
  assign last_i   = (i_q == np_m1);
  assign last_pos = (pos_q == np_m1);

  assign busy_o = (state_q != S_IDLE);
  assign in_acc = start_i && !busy_o;
  assign bad_idx = ({1'b0, resource_index_i} >= nr) ||
                   ((kind_i != KIND_AVAILABLE) && ({1'b0, process_index_i} >= np));

  // The safety search and the release pass walk processes; the rest works on
  // the requesting process.
  assign p_sel = (state_q == S_SAFE_RD || state_q == S_SAFE_EX || state_q == S_ADD_RD ||
                  state_q == S_ADD_EX || state_q == S_REL_RD || state_q == S_REL_EX ||
                  state_q == S_FREE_RD || state_q == S_FREE_EX) ? i_q : pr_q;
  assign rd_addr = {p_sel, j_q};

  assign clm_val = clm_rdv_q ? clm_rd_q : '0;
  assign alc_val = alc_rdv_q ? alc_rd_q : '0;

  always_comb begin
    logic [AmountBits:0] sum;
    amount_t need;
    logic    fa_n, fc_n;

    state_d = state_q;
    j_d     = j_q;
    i_d     = i_q;
    pos_d   = pos_q;
    pr_d    = pr_q;
    fa_d    = fa_q;
    fc_d    = fc_q;
    avail_d = avail_q;
    req_d   = req_q;
    work_d  = work_q;
    fin_d   = fin_q;
    seq_d   = seq_q;
    rv_d    = 1'b0;
    rs_d    = ST_ACCEPTED;
    rp_d    = '0;
    rl_d    = 1'b1;
    clm_we  = 1'b0;
    clm_wa  = {process_index_i, resource_index_i};
    clm_wd  = amount_i;
    alc_we  = 1'b0;
    alc_wa  = {process_index_i, resource_index_i};
    alc_wd  = amount_i;
    sum     = {1'b0, req_q[j_q]} + {1'b0, alc_val};
    need    = (clm_val > alc_val) ? (clm_val - alc_val) : '0;
    fa_n    = fa_q || (req_q[j_q] > avail_q[j_q]);
    fc_n    = fc_q || (sum > {1'b0, clm_val});

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rv_d = 1'b1;
          if (bad_idx) begin
            rs_d = ST_BAD_INDEX;
          end else begin
            unique case (kind_i)
              KIND_CLAIM:     clm_we = 1'b1;
              KIND_ALLOC:     alc_we = 1'b1;
              KIND_AVAILABLE: avail_d[resource_index_i] = amount_i;
              KIND_REQUEST: begin
                req_d[resource_index_i] = amount_i;
                if (last_element_i) begin
                  rv_d    = 1'b0;
                  pr_d    = process_index_i;
                  j_d     = '0;
                  fa_d    = 1'b0;
                  fc_d    = 1'b0;
                  state_d = S_CHK_RD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_CHK_RD: state_d = S_CHK_EX;
      S_CHK_EX: begin
        fa_d = fa_n;
        fc_d = fc_n;
        if (last_j) begin
          j_d = '0;
          if (fa_n || fc_n) begin
            rv_d    = 1'b1;
            rs_d    = fa_n ? ST_EXC_AVAIL : ST_EXC_CLAIM;
            req_d   = '{default: '0};
            state_d = S_IDLE;
          end else begin
            state_d = S_GNT_RD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_CHK_RD;
        end
      end
      S_GNT_RD: state_d = S_GNT_EX;
      S_GNT_EX: begin
        alc_we = 1'b1;
        alc_wa = rd_addr;
        alc_wd = alc_val + req_q[j_q];
        avail_d[j_q] = avail_q[j_q] - req_q[j_q];
        if (last_j) begin
          j_d     = '0;
          state_d = S_SAFE_INIT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_GNT_RD;
        end
      end
      S_SAFE_INIT: begin
        work_d  = avail_q;
        fin_d   = '0;
        pos_d   = '0;
        i_d     = '0;
        j_d     = '0;
        state_d = S_SAFE_RD;
      end
      S_SAFE_RD: begin
        if (fin_q[i_q]) begin
          if (last_i) begin
            j_d     = '0;
            state_d = S_ROLL_RD;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          state_d = S_SAFE_EX;
        end
      end
      S_SAFE_EX: begin
        if (need > work_q[j_q]) begin
          j_d = '0;
          if (last_i) begin
            state_d = S_ROLL_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_SAFE_RD;
          end
        end else if (last_j) begin
          seq_d[pos_q] = i_q;
          fin_d[i_q]   = 1'b1;
          j_d          = '0;
          state_d      = S_ADD_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_SAFE_RD;
        end
      end
      S_ADD_RD: state_d = S_ADD_EX;
      S_ADD_EX: begin
        work_d[j_q] = sat_add(work_q[j_q], alc_val);
        if (last_j) begin
          j_d = '0;
          i_d = '0;
          if (last_pos) begin
            pos_d   = '0;
            req_d   = '{default: '0};
            state_d = S_EMIT;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = S_SAFE_RD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_ADD_RD;
        end
      end
      S_ROLL_RD: state_d = S_ROLL_EX;
      S_ROLL_EX: begin
        alc_we = 1'b1;
        alc_wa = rd_addr;
        alc_wd = alc_val - req_q[j_q];
        avail_d[j_q] = avail_q[j_q] + req_q[j_q];
        if (last_j) begin
          j_d     = '0;
          rv_d    = 1'b1;
          rs_d    = ST_UNSAFE;
          req_d   = '{default: '0};
          state_d = S_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_ROLL_RD;
        end
      end
      S_EMIT: begin
        rv_d = 1'b1;
        rs_d = ST_GRANTED;
        rp_d = seq_q[pos_q];
        rl_d = last_pos;
        if (last_pos) begin
          pos_d   = '0;
          i_d     = '0;
          j_d     = '0;
          state_d = S_REL_RD;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_REL_RD: state_d = S_REL_EX;
      S_REL_EX: begin
        if (alc_val != clm_val) begin
          j_d = '0;
          if (last_i) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_REL_RD;
          end
        end else if (last_j) begin
          j_d     = '0;
          state_d = S_FREE_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_REL_RD;
        end
      end
      S_FREE_RD: state_d = S_FREE_EX;
      S_FREE_EX: begin
        avail_d[j_q] = sat_add(avail_q[j_q], alc_val);
        alc_we = 1'b1;
        alc_wa = rd_addr;
        alc_wd = '0;
        if (last_j) begin
          j_d = '0;
          if (last_i) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_REL_RD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_FREE_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (clm_we) begin
      clm_mem[clm_wa] <= clm_wd;
    end
    if (alc_we) begin
      alc_mem[alc_wa] <= alc_wd;
    end
    clm_rd_q <= clm_mem[rd_addr];
    alc_rd_q <= alc_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clm_vld_q <= '0;
      alc_vld_q <= '0;
      clm_rdv_q <= 1'b0;
      alc_rdv_q <= 1'b0;
    end else begin
      if (clm_we) begin
        clm_vld_q[clm_wa] <= 1'b1;
      end
      if (alc_we) begin
        alc_vld_q[alc_wa] <= 1'b1;
      end
      clm_rdv_q <= clm_vld_q[rd_addr];
      alc_rdv_q <= alc_vld_q[rd_addr];
    end
  end

  // Safe sequence entries are always written before they are shown.
  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    work_q <= work_d;
    rp_q   <= rp_d;
    rs_q   <= rs_d;
    rl_q   <= rl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      proc_cnt_q <= 5'(MaxProcesses);
      res_cnt_q  <= 4'(MaxResources);
      avail_q    <= '{default: '0};
      req_q      <= '{default: '0};
      fin_q      <= '0;
      j_q        <= '0;
      i_q        <= '0;
      pos_q      <= '0;
      pr_q       <= '0;
      fa_q       <= 1'b0;
      fc_q       <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      avail_q <= avail_d;
      req_q   <= req_d;
      fin_q   <= fin_d;
      j_q     <= j_d;
      i_q     <= i_d;
      pos_q   <= pos_d;
      pr_q    <= pr_d;
      fa_q    <= fa_d;
      fc_q    <= fc_d;
      rv_q    <= rv_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgProcessCount) begin
          proc_cnt_q <= cfg_data_i;
        end else begin
          proc_cnt_q <= proc_cnt_q;
        end
        if (cfg_index_i == CfgResourceCount) begin
          res_cnt_q <= cfg_data_i[3:0];
        end
      end
    end
  end

  assign result_valid_o     = rv_q;
  assign status_o           = rs_q;
  assign sequence_process_o = rp_q;
  assign last_result_o      = rl_q;

  // Only a grant produces more than one result, so a non-final result must be a grant.
  a_multi_is_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> status_o == ST_GRANTED)
    else $error("non-final result that is not a grant");

  // A table load always answers in the next cycle.
  a_load_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && kind_i != KIND_REQUEST |=> result_valid_o && last_result_o)
    else $error("load without a single result");

  // Once a grant sequence has started in S_EMIT, it stays there until its final result.
  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && !last_pos |=> state_q == S_EMIT)
    else $error("grant sequence broken off");

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

endmodule
